FILE: rtl/mm3_pkg.sv
// shared types, constants and helper functions for the murmur3 stream hash
package mm3_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD = 1'd1;

    // mixing constants
    localparam logic [WORD_W-1:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MIX_C2    = 32'h1b873593;
    localparam logic [WORD_W-1:0] MIX_N     = 32'he6546b64;
    localparam logic [WORD_W-1:0] FIN_C1    = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] FIN_C2    = 32'hc2b2ae35;
    localparam logic [WORD_W-1:0] FOLD_WORD = 32'h20202020;

    // byte counts
    localparam logic [COUNT_W-1:0] CNT_NONE = 3'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [COUNT_W-1:0] CNT_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] CNT_FULL = 3'd4;

    // classified item handed from the front to the back
    typedef struct packed {
        logic [WORD_W-1:0]  k;
        logic [COUNT_W-1:0] count;
        logic               last;
    } mm3_item_t;

    // mask of the valid low bytes of a word
    function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
        logic [WORD_W-1:0] m;
        begin
            unique case (count)
                CNT_NONE:  m = 32'h00000000;
                CNT_ONE:   m = 32'h000000ff;
                CNT_TWO:   m = 32'h0000ffff;
                CNT_THREE: m = 32'h00ffffff;
                default:   m = 32'hffffffff;
            endcase
            return m;
        end
    endfunction

    function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
        return {x[18:0], x[31:19]};
    endfunction

endpackage

FILE: rtl/mm3_if.sv
// valid/ready channel interfaces for message words and hash results
interface mm3_in_if;
    logic                          valid;
    logic                          ready;
    logic [mm3_pkg::WORD_W-1:0]    data_word;
    logic [mm3_pkg::COUNT_W-1:0]   byte_count;
    logic                          last;

    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface mm3_out_if;
    logic                          valid;
    logic                          ready;
    logic [mm3_pkg::WORD_W-1:0]    hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

FILE: rtl/mm3_front.sv
// front end: takes message words, drops bubbles, folds case and masks the tail
module mm3_front
(
    input  logic                 case_fold,
    mm3_in_if.sink               msg,
    input  logic                 q_full,
    output logic                 q_push,
    output mm3_pkg::mm3_item_t   q_item
);

    logic [mm3_pkg::COUNT_W-1:0] count_sat;
    logic                        bubble;
    logic [mm3_pkg::WORD_W-1:0]  folded;

    // saturate the byte count and spot idle bubbles
    always_comb
    begin
        count_sat = (msg.byte_count > mm3_pkg::CNT_FULL) ? mm3_pkg::CNT_FULL : msg.byte_count;
        bubble    = (count_sat == mm3_pkg::CNT_NONE) && !msg.last;
    end

    // case fold and tail masking
    always_comb
    begin
        folded         = case_fold ? (msg.data_word | mm3_pkg::FOLD_WORD) : msg.data_word;
        q_item.k       = folded & mm3_pkg::byte_mask(count_sat);
        q_item.count   = count_sat;
        q_item.last    = msg.last || (count_sat != mm3_pkg::CNT_FULL);
    end

    // a transfer always completes while the queue has room; bubbles are discarded
    assign msg.ready = !q_full;
    assign q_push    = msg.valid && !q_full && !bubble;

endmodule

FILE: rtl/mm3_queue.sv
// short item queue between the front and the back
module mm3_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mm3_pkg::mm3_item_t   push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output mm3_pkg::mm3_item_t   head
);

    mm3_pkg::mm3_item_t              slot_reg [mm3_pkg::QDEPTH];
    logic [mm3_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [mm3_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [mm3_pkg::QCNT_W-1:0]      fill_reg, fill_next;
    logic                            do_push, do_pop;

    assign full      = (fill_reg == mm3_pkg::QCNT_W'(mm3_pkg::QDEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mm3_pkg::QPTR_W'(mm3_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mm3_pkg::QPTR_W'(mm3_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/mm3_back.sv
// back end: block mixing, length fold and finalizer, with the result register
module mm3_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mm3_pkg::WORD_W-1:0] seed,
    input  logic                       q_not_empty,
    input  mm3_pkg::mm3_item_t         q_head,
    output logic                       q_pop,
    mm3_out_if.source                  digest
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_MIX  = 3'd3;
    localparam logic [2:0] S_FIN0 = 3'd4;
    localparam logic [2:0] S_FIN1 = 3'd5;
    localparam logic [2:0] S_FIN2 = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic                        in_msg_reg, in_msg_next;
    logic                        last_reg, last_next;
    logic                        full_reg, full_next;
    logic [mm3_pkg::WORD_W-1:0]  k_reg, k_next;
    logic [mm3_pkg::WORD_W-1:0]  h_reg, h_next;
    logic [mm3_pkg::WORD_W-1:0]  tot_reg, tot_next;
    logic                        out_valid_reg, out_valid_next;
    logic [mm3_pkg::WORD_W-1:0]  out_hash_reg, out_hash_next;

    logic                        out_free;
    logic [mm3_pkg::WORD_W-1:0]  mixed;
    logic [mm3_pkg::WORD_W-1:0]  rot_h;
    logic [mm3_pkg::WORD_W-1:0]  fin_x;

    assign out_free = !out_valid_reg || digest.ready;

    // block mix: rotate by 13, then h * 5 + n as shift and adds
    always_comb
    begin
        mixed = h_reg ^ k_reg;
        rot_h = mm3_pkg::rotl13(mixed);
        if (full_reg)
        begin
            mixed = rot_h + {rot_h[29:0], 2'b00} + mm3_pkg::MIX_N;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        in_msg_next    = in_msg_reg;
        last_next      = last_reg;
        full_next      = full_reg;
        k_next         = k_reg;
        h_next         = h_reg;
        tot_next       = tot_reg;
        out_valid_next = out_valid_reg && !digest.ready;
        out_hash_next  = out_hash_reg;
        q_pop          = 1'b0;
        fin_x          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop     = 1'b1;
                    k_next    = q_head.k;
                    last_next = q_head.last;
                    full_next = (q_head.count == mm3_pkg::CNT_FULL);
                    h_next    = in_msg_reg ? h_reg : seed;
                    tot_next  = (in_msg_reg ? tot_reg : '0) + mm3_pkg::WORD_W'(q_head.count);
                    state_next = (q_head.count == mm3_pkg::CNT_NONE) ? S_FIN0 : S_MUL1;
                end
            end
            S_MUL1:
            begin
                k_next     = k_reg * mm3_pkg::MIX_C1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                k_next     = mm3_pkg::rotl15(k_reg) * mm3_pkg::MIX_C2;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                h_next = mixed;
                if (last_reg)
                begin
                    state_next = S_FIN0;
                end
                else
                begin
                    in_msg_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FIN0:
            begin
                fin_x      = h_reg ^ tot_reg;
                fin_x      = fin_x ^ {16'd0, fin_x[31:16]};
                h_next     = fin_x * mm3_pkg::FIN_C1;
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                fin_x      = h_reg ^ {13'd0, h_reg[31:13]};
                h_next     = fin_x * mm3_pkg::FIN_C2;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                if (out_free)
                begin
                    out_hash_next  = h_reg ^ {16'd0, h_reg[31:16]};
                    out_valid_next = 1'b1;
                    in_msg_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        full_reg     <= full_next;
        k_reg        <= k_next;
        h_reg        <= h_next;
        tot_reg      <= tot_next;
        out_hash_reg <= out_hash_next;
    end

    assign digest.valid      = out_valid_reg;
    assign digest.hash_value = out_hash_reg;

    // items leave the queue only when the sequencer is free
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped while the sequencer is busy");

    // a new result only comes out of the last finalizer step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN2)
        else $error("result raised outside the finalizer");

    // a word that is not last returns to idle with the message open
    a_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX) && !last_reg |=> (state_reg == S_IDLE) && in_msg_reg)
        else $error("mid-message word did not keep the message open");

    // an empty end goes straight to the finalizer
    a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && (q_head.count == mm3_pkg::CNT_NONE) |=> state_reg == S_FIN0)
        else $error("empty end did not start the finalizer");

endmodule

FILE: rtl/murmur3_32_stream_hash.sv
// top level of the streaming 32-bit murmur3 hash
//
// Words of a message arrive on msg (valid/ready), four little-endian bytes
// each, with byte_count valid low bytes and last on the final word. A word
// of four bytes is a full block; one to three bytes end the message as the
// tail; a count of zero with last ends it with no extra bytes, and with last
// low it is an idle bubble that is taken and dropped. One hash per message
// leaves on digest (valid/ready) from an output register.
// Registers are written through wr_en/wr_index/wr_data: seed at index 0 and
// case_fold at index 1; write them only while no message is in flight.
// Words are mixed one at a time by the shared sequencer, through idle, the
// two multiply steps and the mix; it pops the next word only when idle.
// The last word then passes the finalizer steps, and the hash reaches
// digest.valid through the output register. A two-entry queue lets msg
// keep accepting until it fills while the back end works or while digest
// is stalled; a stalled result holds in its register and the finalizer
// waits behind it. Reset clears the queue, the sequencer, the result
// valid flag and sets both registers to zero; no clearing pass is needed.
module murmur3_32_stream_hash
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [mm3_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [mm3_pkg::WORD_W-1:0]    wr_data,
    mm3_in_if.sink                        msg,
    mm3_out_if.source                     digest
);

    logic [mm3_pkg::WORD_W-1:0] seed_reg;
    logic                       case_fold_reg;

    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_not_empty;
    mm3_pkg::mm3_item_t         q_item;
    mm3_pkg::mm3_item_t         q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            case_fold_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                mm3_pkg::REG_SEED:      seed_reg      <= wr_data;
                mm3_pkg::REG_CASE_FOLD: case_fold_reg <= wr_data[0];
                default:                ;
            endcase
        end
    end

    // word classification
    mm3_front u_front
    (
        .case_fold (case_fold_reg),
        .msg       (msg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    // decoupling queue
    mm3_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // mixing and finalizer
    mm3_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .digest      (digest)
    );

endmodule
